>>> sv/ssclk_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment clock formatter package
// Shared types, segment constants and small encoding helpers.
// ----------------------------------------------------------------------------
package ssclk_pkg;

   typedef enum logic [2:0] {
      KIND_TIME    = 3'd0,
      KIND_ATTEMPT = 3'd1,
      KIND_MODE    = 3'd2,
      KIND_ERROR   = 3'd3,
      KIND_ANIM    = 3'd4,
      KIND_CLEAR   = 3'd5
   } kind_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [4:0] hour;
      logic [5:0] minute;
      logic       colon_on;
      logic       show_hour;
      logic       show_minute;
      logic [7:0] attempt_count;
      logic [7:0] error_code;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] seg_digit0;
      logic [7:0] seg_digit1;
      logic [7:0] seg_digit2;
      logic [7:0] seg_digit3;
   } rsp_payload_type;

   localparam logic [7:0] SEG_BLANK   = 8'h00;
   localparam logic [7:0] SEG_DASH    = 8'h40;
   localparam logic [7:0] SEG_POINT   = 8'h80;
   localparam logic [7:0] SEG_LOWER_H = 8'h74;
   localparam logic [7:0] SEG_CAP_E   = 8'h79;
   localparam logic [7:0] SEG_LOWER_R = 8'h50;

   localparam logic [2:0] SWEEP_OFF   = 3'd4;
   localparam logic [2:0] SWEEP_RIGHT = 3'd3;

   localparam logic [7:0] DIGIT_FONT [10] = '{
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
   };

   function automatic logic [7:0] glyph(input logic [3:0] d);
      logic [7:0] g;
      g = SEG_BLANK;
      if (d < 4'd10) begin
         g = DIGIT_FONT[d];
      end
      return g;
   endfunction

   // n mod 10 for an 8-bit value: n*205 >> 11 is exact n/10 here
   function automatic logic [3:0] mod10_u8(input logic [7:0] n);
      logic [15:0] prod;
      logic [4:0]  q;
      logic [7:0]  r;
      prod = 16'(n) * 16'd205;
      q    = prod[15:11];
      r    = n - 8'(q) * 8'd10;
      return r[3:0];
   endfunction

endpackage

>>> sv/seven_segment_clock_formatter_unit.sv
// ----------------------------------------------------------------------------
// Seven-segment clock formatter
// Turns display commands into the four segment bytes of a clock display.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : command beats (kind, hour, minute, flags, counts), valid/stall.
//   rsp_*  : one beat of four segment bytes per command, leftmost digit first.
//   csr_*  : one-bit twelve_hour register, always ready; write only when idle.
// Path: a command is held in the input register, encoded by combinational
//   logic and captured in the result register, which drives rsp.
// Throughput: one command per cycle while req_stall is low; the input and
//   result registers form a two-deep pipeline, so a new command is taken
//   while a result waits.
// Stall: when rsp_stall holds a result, one more command is held in the
//   input register, then req_stall rises.
// Reset: synchronous; empties both registers, twelve_hour goes to 0 and the
//   sweep dash goes to its off-display position moving leftward.
// ----------------------------------------------------------------------------
module seven_segment_clock_formatter_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ssclk_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ssclk_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data
);

   logic                       twelve_hour_ff;
   logic                       s1_valid_ff, s1_valid_in;
   ssclk_pkg::req_payload_type s1_data_ff;
   logic                       out_valid_ff, out_valid_in;
   ssclk_pkg::rsp_payload_type out_data_ff, out_data_in;
   logic [2:0]                 sweep_pos_ff, sweep_pos_in;
   logic                       sweep_left_ff, sweep_left_in;

   logic                       load_s1;
   logic                       advance;
   ssclk_pkg::kind_type        kind;

   logic [4:0] dh;
   logic [4:0] hour_mod;
   logic [1:0] hour_tens;
   logic [3:0] hour_ones;
   logic [2:0] min_tens;
   logic [5:0] min_ones;
   logic [2:0] dash_pos;

   assign csr_ready = 1'b1;
   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && out_valid_ff && rsp_stall;
   assign load_s1   = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign kind      = ssclk_pkg::kind_type'(s1_data_ff.kind);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load_s1) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         out_valid_in = s1_valid_ff;
      end
   end

   // hour digits
   always_comb begin
      hour_mod = s1_data_ff.hour;
      if (s1_data_ff.hour >= 5'd24) begin
         hour_mod = s1_data_ff.hour - 5'd24;
      end else if (s1_data_ff.hour >= 5'd12) begin
         hour_mod = s1_data_ff.hour - 5'd12;
      end
      dh = s1_data_ff.hour;
      if (twelve_hour_ff) begin
         dh = (hour_mod == 5'd0) ? 5'd12 : hour_mod;
      end
      if (dh >= 5'd30) begin
         hour_tens = 2'd3;
      end else if (dh >= 5'd20) begin
         hour_tens = 2'd2;
      end else if (dh >= 5'd10) begin
         hour_tens = 2'd1;
      end else begin
         hour_tens = 2'd0;
      end
      hour_ones = 4'(dh - 5'(hour_tens) * 5'd10);
   end

   // minute digits
   always_comb begin
      if (s1_data_ff.minute >= 6'd60) begin
         min_tens = 3'd6;
      end else if (s1_data_ff.minute >= 6'd50) begin
         min_tens = 3'd5;
      end else if (s1_data_ff.minute >= 6'd40) begin
         min_tens = 3'd4;
      end else if (s1_data_ff.minute >= 6'd30) begin
         min_tens = 3'd3;
      end else if (s1_data_ff.minute >= 6'd20) begin
         min_tens = 3'd2;
      end else if (s1_data_ff.minute >= 6'd10) begin
         min_tens = 3'd1;
      end else begin
         min_tens = 3'd0;
      end
      min_ones = s1_data_ff.minute - 6'(min_tens) * 6'd10;
   end

   // sweep step
   always_comb begin
      sweep_pos_in  = sweep_pos_ff;
      sweep_left_in = sweep_left_ff;
      if (advance && kind == ssclk_pkg::KIND_ANIM) begin
         if (sweep_left_ff) begin
            sweep_pos_in = sweep_pos_ff - 3'd1;
            if (sweep_pos_in == 3'd0) begin
               sweep_left_in = 1'b0;
            end
         end else begin
            sweep_pos_in = sweep_pos_ff + 3'd1;
            if (sweep_pos_in == ssclk_pkg::SWEEP_RIGHT) begin
               sweep_left_in = 1'b1;
            end
         end
      end
   end

   assign dash_pos = sweep_pos_ff;

   // segment encoding
   always_comb begin
      out_data_in = '0;
      case (kind)
         ssclk_pkg::KIND_TIME: begin
            if (s1_data_ff.show_hour) begin
               if (hour_tens != 2'd0) begin
                  out_data_in.seg_digit0 = ssclk_pkg::glyph(4'(hour_tens));
               end
               out_data_in.seg_digit1 = ssclk_pkg::glyph(hour_ones);
            end
            if (s1_data_ff.colon_on) begin
               out_data_in.seg_digit1 = out_data_in.seg_digit1 | ssclk_pkg::SEG_POINT;
            end
            if (s1_data_ff.show_minute) begin
               out_data_in.seg_digit2 = ssclk_pkg::glyph(4'(min_tens));
               out_data_in.seg_digit3 = ssclk_pkg::glyph(min_ones[3:0]);
            end
         end
         ssclk_pkg::KIND_ATTEMPT: begin
            out_data_in.seg_digit0 = ssclk_pkg::SEG_DASH;
            if (s1_data_ff.attempt_count >= 8'd2) begin
               out_data_in.seg_digit1 = ssclk_pkg::SEG_DASH;
            end
            if (s1_data_ff.attempt_count >= 8'd3) begin
               out_data_in.seg_digit2 = ssclk_pkg::SEG_DASH;
            end
            if (s1_data_ff.attempt_count >= 8'd4) begin
               out_data_in.seg_digit3 = ssclk_pkg::SEG_DASH;
            end
         end
         ssclk_pkg::KIND_MODE: begin
            out_data_in.seg_digit0 = ssclk_pkg::glyph(twelve_hour_ff ? 4'd1 : 4'd2);
            out_data_in.seg_digit1 = ssclk_pkg::glyph(twelve_hour_ff ? 4'd2 : 4'd4);
            out_data_in.seg_digit2 = ssclk_pkg::SEG_LOWER_H;
         end
         ssclk_pkg::KIND_ERROR: begin
            out_data_in.seg_digit0 = ssclk_pkg::SEG_CAP_E;
            out_data_in.seg_digit1 = ssclk_pkg::SEG_LOWER_R;
            out_data_in.seg_digit2 = ssclk_pkg::SEG_LOWER_R;
            out_data_in.seg_digit3 =
               ssclk_pkg::glyph(ssclk_pkg::mod10_u8(s1_data_ff.error_code));
         end
         ssclk_pkg::KIND_ANIM: begin
            case (dash_pos)
               3'd0:    out_data_in.seg_digit0 = ssclk_pkg::SEG_DASH;
               3'd1:    out_data_in.seg_digit1 = ssclk_pkg::SEG_DASH;
               3'd2:    out_data_in.seg_digit2 = ssclk_pkg::SEG_DASH;
               3'd3:    out_data_in.seg_digit3 = ssclk_pkg::SEG_DASH;
               default: out_data_in = '0;
            endcase
         end
         default: begin
            out_data_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         twelve_hour_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         sweep_pos_ff   <= ssclk_pkg::SWEEP_OFF;
         sweep_left_ff  <= 1'b1;
      end else begin
         if (csr_valid && csr_ready) begin
            twelve_hour_ff <= csr_data;
         end
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
         sweep_pos_ff  <= sweep_pos_in;
         sweep_left_ff <= sweep_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

>>> sv/ssclk_checker.sv
// ----------------------------------------------------------------------------
// Seven-segment clock formatter checker
// Port-level checks on reset, result hold and segment encoding.
// ----------------------------------------------------------------------------
module ssclk_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input ssclk_pkg::rsp_payload_type rsp_data
);

   // a held result beat keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // reset empties both pipeline registers
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // only digit 1 carries a point (the colon)
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.seg_digit0[7] && !rsp_data.seg_digit2[7]
                    && !rsp_data.seg_digit3[7])
      else $error("point lit outside digit 1");

   // an E in digit 0 is always the error text
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.seg_digit0 == ssclk_pkg::SEG_CAP_E
         |-> rsp_data.seg_digit1 == ssclk_pkg::SEG_LOWER_R
             && rsp_data.seg_digit2 == ssclk_pkg::SEG_LOWER_R)
      else $error("broken error text");

endmodule

bind seven_segment_clock_formatter_unit ssclk_checker u_ssclk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> bench/ssclk_display_checker.sv
// ----------------------------------------------------------------------------
// Seven-segment clock formatter checker
// Watches the command, result and register channels, predicts the four
// segment bytes of every accepted command and compares each result beat.
// ----------------------------------------------------------------------------
module ssclk_display_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  ssclk_pkg::req_payload_type req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  ssclk_pkg::rsp_payload_type rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic                       csr_data,
   output int                         fail_count,
   output int                         pending_frames,
   output int                         frames_checked
);

   ssclk_pkg::rsp_payload_type expected_frames [$];

   logic       twelve_hour_mode = 1'b0;
   logic [2:0] dash_pos         = ssclk_pkg::SWEEP_OFF;
   logic       dash_leftward    = 1'b1;

   function automatic logic [7:0] digit_segments(input int unsigned d);
      logic [7:0] s;
      case (d)
         0: s = 8'h3f;
         1: s = 8'h06;
         2: s = 8'h5b;
         3: s = 8'h4f;
         4: s = 8'h66;
         5: s = 8'h6d;
         6: s = 8'h7d;
         7: s = 8'h07;
         8: s = 8'h7f;
         9: s = 8'h6f;
         default: s = ssclk_pkg::SEG_BLANK;
      endcase
      return s;
   endfunction

   // segment bytes for one command, using the current mode and sweep position
   function automatic ssclk_pkg::rsp_payload_type encode_display(
      input ssclk_pkg::req_payload_type cmd);
      logic [7:0]  d [4];
      int unsigned shown_hour;
      int unsigned dashes;
      d = '{ssclk_pkg::SEG_BLANK, ssclk_pkg::SEG_BLANK,
            ssclk_pkg::SEG_BLANK, ssclk_pkg::SEG_BLANK};
      case (ssclk_pkg::kind_type'(cmd.kind))
         ssclk_pkg::KIND_TIME: begin
            shown_hour = 32'(cmd.hour);
            if (twelve_hour_mode) begin
               shown_hour = cmd.hour % 12;
               if (shown_hour == 0) shown_hour = 12;
            end
            if (cmd.show_hour) begin
               if (shown_hour >= 10) d[0] = digit_segments(shown_hour / 10);
               d[1] = digit_segments(shown_hour % 10);
            end
            // colon survives hour blanking
            if (cmd.colon_on) d[1] = d[1] | ssclk_pkg::SEG_POINT;
            if (cmd.show_minute) begin
               d[2] = digit_segments(cmd.minute / 10);
               d[3] = digit_segments(cmd.minute % 10);
            end
         end
         ssclk_pkg::KIND_ATTEMPT: begin
            dashes = 32'(cmd.attempt_count);
            if (dashes == 0) dashes = 1;
            if (dashes > 4) dashes = 4;
            for (int i = 0; i < dashes; i++) d[i] = ssclk_pkg::SEG_DASH;
         end
         ssclk_pkg::KIND_MODE: begin
            d[0] = digit_segments(twelve_hour_mode ? 1 : 2);
            d[1] = digit_segments(twelve_hour_mode ? 2 : 4);
            d[2] = ssclk_pkg::SEG_LOWER_H;
         end
         ssclk_pkg::KIND_ERROR: begin
            d[0] = ssclk_pkg::SEG_CAP_E;
            d[1] = ssclk_pkg::SEG_LOWER_R;
            d[2] = ssclk_pkg::SEG_LOWER_R;
            d[3] = digit_segments(cmd.error_code % 10);
         end
         ssclk_pkg::KIND_ANIM: begin
            if (dash_pos < ssclk_pkg::SWEEP_OFF) d[dash_pos[1:0]] = ssclk_pkg::SEG_DASH;
         end
         default: ;
      endcase
      return {d[0], d[1], d[2], d[3]};
   endfunction

   always @(posedge clock) begin
      ssclk_pkg::rsp_payload_type want;
      if (reset) begin
         expected_frames.delete();
         twelve_hour_mode = 1'b0;
         dash_pos         = ssclk_pkg::SWEEP_OFF;
         dash_leftward    = 1'b1;
         pending_frames   = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               fail_count++;
               $display("%0t: result beat %08h with no command outstanding",
                        $time, rsp_data);
            end else begin
               want = expected_frames.pop_front();
               for (int i = 0; i < 4; i++) begin
                  if (want[31-8*i -: 8] !== rsp_data[31-8*i -: 8]) begin
                     fail_count++;
                     $display("%0t: seg_digit%0d expected %02h actual %02h",
                              $time, i, want[31-8*i -: 8], rsp_data[31-8*i -: 8]);
                  end
               end
               frames_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            expected_frames.push_back(encode_display(req_data));
            // bounce between digit 0 and digit 3 once the dash is on screen
            if (req_data.kind == ssclk_pkg::KIND_ANIM) begin
               if (dash_leftward) begin
                  dash_pos = dash_pos - 3'd1;
                  if (dash_pos == 3'd0) dash_leftward = 1'b0;
               end else begin
                  dash_pos = dash_pos + 3'd1;
                  if (dash_pos == ssclk_pkg::SWEEP_RIGHT) dash_leftward = 1'b1;
               end
            end
         end
         if (csr_valid && csr_ready) twelve_hour_mode = csr_data;
         pending_frames = expected_frames.size();
      end
   end

endmodule

>>> bench/seven_segment_clock_formatter_unit_tb.sv
// ----------------------------------------------------------------------------
// Seven-segment clock formatter testbench
// Directed and random display commands in both hour modes, with bursty
// command traffic and a stalling result side; results are checked by
// ssclk_display_checker.
// ----------------------------------------------------------------------------
module seven_segment_clock_formatter_unit_tb;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 190;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int REQ_BITS      = $bits(ssclk_pkg::req_payload_type);

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   ssclk_pkg::req_payload_type req_data  = '0;
   logic                       rsp_stall = 1'b0;
   logic                       csr_valid = 1'b0;
   logic                       csr_data  = 1'b0;
   logic                       req_stall;
   logic                       rsp_valid;
   ssclk_pkg::rsp_payload_type rsp_data;
   logic                       csr_ready;

   int fail_count;
   int pending_frames;
   int frames_checked;
   int cycle_count   = 0;
   int commands_sent = 0;
   int mode_writes   = 0;
   int burst_left    = 0;

   always #4 clock = ~clock;

   seven_segment_clock_formatter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   ssclk_display_checker display_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .pending_frames (pending_frames),
      .frames_checked (frames_checked)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   function automatic ssclk_pkg::req_payload_type make_cmd(
      input logic [2:0] kind, input logic [4:0] hour, input logic [5:0] minute,
      input logic colon, input logic show_h, input logic show_m,
      input logic [7:0] attempts, input logic [7:0] err);
      ssclk_pkg::req_payload_type c;
      c.kind          = kind;
      c.hour          = hour;
      c.minute        = minute;
      c.colon_on      = colon;
      c.show_hour     = show_h;
      c.show_minute   = show_m;
      c.attempt_count = attempts;
      c.error_code    = err;
      return c;
   endfunction

   function automatic ssclk_pkg::req_payload_type random_cmd();
      ssclk_pkg::req_payload_type c;
      int unsigned                pick;
      c    = REQ_BITS'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 30)      c.kind = ssclk_pkg::KIND_TIME;
      else if (pick < 42) c.kind = ssclk_pkg::KIND_ATTEMPT;
      else if (pick < 50) c.kind = ssclk_pkg::KIND_MODE;
      else if (pick < 62) c.kind = ssclk_pkg::KIND_ERROR;
      else if (pick < 82) c.kind = ssclk_pkg::KIND_ANIM;
      else if (pick < 92) c.kind = ssclk_pkg::KIND_CLEAR;
      else                c.kind = 3'($urandom_range(6, 7));
      // mostly legal clock values, now and then out of range
      c.hour   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                             : 5'($urandom_range(0, 23));
      c.minute = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                             : 6'($urandom_range(0, 59));
      if ($urandom_range(0, 1) == 0) c.attempt_count = 8'($urandom_range(0, 6));
      return c;
   endfunction

   // one command beat, then maybe a gap to end the burst
   task automatic send_command(input ssclk_pkg::req_payload_type cmd);
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (req_stall);
      commands_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(30, 80);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // block must be empty before the mode bit changes
   task automatic wait_idle();
      @(posedge clock);
      while (pending_frames != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_twelve_hour(input logic value);
      req_valid <= 1'b0;
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_writes++;
   endtask

   // receiver: stall patterns in segments, plus two long hold-offs
   initial begin
      int          mode;
      int          seg_len;
      int          holds;
      logic        s;
      holds = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds < 2 && cycle_count > 400 + holds * 3000) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds++;
         end else begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(4, 64);
            for (int j = 0; j < seg_len; j++) begin
               case (mode)
                  0: s = 1'b0;
                  1: s = ($urandom_range(0, 3) == 0);
                  2: s = ($urandom_range(0, 3) != 0);
                  default: s = j[0];
               endcase
               rsp_stall <= s;
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 24-hour mode from reset
      send_command(make_cmd(ssclk_pkg::KIND_TIME, 5'd0, 6'd0, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_TIME, 5'd23, 6'd59, 1'b0, 1'b1, 1'b1,
                            8'hff, 8'hff));
      send_command(make_cmd(ssclk_pkg::KIND_TIME, 5'd9, 6'd5, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_TIME, 5'd31, 6'd63, 1'b1, 1'b1, 1'b1,
                            8'd0, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_TIME, 5'd12, 6'd34, 1'b1, 1'b0, 1'b1,
                            8'd0, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_TIME, 5'd10, 6'd45, 1'b0, 1'b1, 1'b0,
                            8'd0, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_TIME, 5'd17, 6'd20, 1'b1, 1'b0, 1'b0,
                            8'd0, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_ATTEMPT, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0,
                            8'd0, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_ATTEMPT, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0,
                            8'd2, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_ATTEMPT, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0,
                            8'd4, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_ATTEMPT, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0,
                            8'd5, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_ATTEMPT, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0,
                            8'd255, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_MODE, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_ERROR, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0,
                            8'd0, 8'd9));
      send_command(make_cmd(ssclk_pkg::KIND_ERROR, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0,
                            8'd0, 8'd255));
      send_command(make_cmd(ssclk_pkg::KIND_ERROR, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0,
                            8'd0, 8'd10));
      // sweep: off screen, then down to digit 0 and back
      repeat (6) send_command(make_cmd(ssclk_pkg::KIND_ANIM, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0,
                                       8'd0, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_CLEAR, 5'd23, 6'd59, 1'b1, 1'b1, 1'b1,
                            8'hff, 8'hff));
      send_command(make_cmd(3'd7, 5'd23, 6'd59, 1'b1, 1'b1, 1'b1, 8'hff, 8'hff));

      // 12-hour mode: midnight and noon show 12, afternoon folds down
      set_twelve_hour(1'b1);
      send_command(make_cmd(ssclk_pkg::KIND_TIME, 5'd0, 6'd7, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_TIME, 5'd12, 6'd0, 1'b0, 1'b1, 1'b1,
                            8'd0, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_TIME, 5'd13, 6'd30, 1'b1, 1'b1, 1'b1,
                            8'd0, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_TIME, 5'd23, 6'd59, 1'b1, 1'b1, 1'b1,
                            8'd0, 8'd0));
      send_command(make_cmd(ssclk_pkg::KIND_MODE, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_twelve_hour(phase[0]);
         repeat (PHASE_ITEMS) send_command(random_cmd());
      end

      req_valid <= 1'b0;
      wait_idle();

      $display("%0d commands sent, %0d result beats checked, %0d mode writes, %0d cycles",
               commands_sent, frames_checked, mode_writes, cycle_count);
      $display("covered all command kinds in both hour modes under bursty input and output hold-off");
      if (fail_count == 0 && pending_frames == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, pending_frames);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/ssclk_pkg.sv
sv/seven_segment_clock_formatter_unit.sv
sv/ssclk_checker.sv
bench/ssclk_display_checker.sv
bench/seven_segment_clock_formatter_unit_tb.sv
